FILE: rtl/core/mntf_pkg.sv
package mntf_pkg;

  // Fixed geometry of the note space.
  localparam int NOTES       = 128;
  localparam int DEVICES_DEF = 4;

  // Largest lockout that a mapping entry can hold.
  localparam logic [9:0] OVERHIT_MAX = 10'd999;

  // Upper nibble of a note-on status byte.
  localparam logic [3:0] NOTE_ON_NIBBLE = 4'h9;

  // Operation codes of an input word.
  localparam logic [1:0] OP_MIDI  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_STATS = 2'd2;

  // Outcome codes of a result word.
  localparam logic [2:0] OUT_IGNORED  = 3'd0;
  localparam logic [2:0] OUT_UNMAPPED = 3'd1;
  localparam logic [2:0] OUT_VEL_BLK  = 3'd2;
  localparam logic [2:0] OUT_OVR_BLK  = 3'd3;
  localparam logic [2:0] OUT_PRESSED  = 3'd4;
  localparam logic [2:0] OUT_WRITTEN  = 3'd5;
  localparam logic [2:0] OUT_STATS    = 3'd6;

  // Input word.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  device;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [31:0] now_ms;
    logic        entry_mapped;
    logic [7:0]  entry_key;
    logic [6:0]  entry_vel_threshold;
    logic [9:0]  entry_overhit_ms;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  outcome;
    logic [7:0]  key_code;
    logic [31:0] elapsed_ms;
    logic [31:0] hit_count;
    logic [39:0] velocity_sum;
    logic [31:0] velocity_blocks;
    logic [31:0] overhit_blocks;
  } out_word_t;

  // One table entry: the mapping plus its timing and statistics.
  typedef struct packed {
    logic        mapped;
    logic [7:0]  key;
    logic [6:0]  vel_thr;
    logic [9:0]  overhit;
    logic [31:0] last_hit;
    logic [31:0] hits;
    logic [39:0] vsum;
    logic [31:0] vblk;
    logic [31:0] oblk;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic clear_wr;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } ctrl_sts_t;

endpackage

FILE: rtl/core/mntf_ctrl.sv
module mntf_ctrl
  import mntf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd,
  input  ctrl_sts_t sts
);

  state_t state;
  state_t state_next;

  // State register; reset begins the table clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/core/mntf_dp.sv
module mntf_dp
  import mntf_pkg::*;
#(
  parameter int DEVICES = DEVICES_DEF
)
(
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  item,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  output out_word_t result,
  output logic      done
);

  localparam int ENTRIES = DEVICES * NOTES;
  localparam int AW      = $clog2(ENTRIES);

  entry_t          mem [ENTRIES];
  entry_t          rd_q;
  in_word_t        item_q;
  logic [AW-1:0]   idx_q;
  logic            ok_q;
  logic            dev_ok_q;
  logic [AW-1:0]   clr_addr;
  logic            stats_enable;

  logic [8:0]      in_idx_raw;
  logic [AW-1:0]   in_idx;
  logic            in_dev_ok;
  logic            in_ok;

  entry_t          new_e;
  logic            upd_en;
  out_word_t       res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  // Table index of the incoming word; upper bits are zero whenever it is in range.
  assign in_idx_raw = {item.device, item.data1[6:0]};
  assign in_idx     = AW'(in_idx_raw);
  assign in_dev_ok  = (32'(item.device) < 32'(DEVICES));
  assign in_ok      = in_dev_ok && (item.data1[7] == 1'b0);

  // Statistics enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stats_enable <= 1'b0;
    end else if (cfg_we) begin
      stats_enable <= cfg_wdata;
    end
  end

  // Clearing pass address, one entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign sts.clear_last = (clr_addr == AW'(ENTRIES - 1));

  // Capture the accepted word and its decoded index.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q   <= item;
      idx_q    <= in_idx;
      ok_q     <= in_ok;
      dev_ok_q <= in_dev_ok;
    end
  end

  // Table read, registered.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_q <= mem[in_idx];
    end
  end

  // Table write: zeros during the clearing pass, else the updated entry.
  assign mem_we    = cmd.clear_wr | (cmd.exec & upd_en);
  assign mem_waddr = cmd.clear_wr ? clr_addr : idx_q;
  assign mem_wdata = cmd.clear_wr ? entry_t'('0) : new_e;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Work out the result and the entry write-back for the captured word.
  always_comb begin
    logic [40:0] vsum_ext;
    logic [31:0] diff;
    res      = '0;
    new_e    = rd_q;
    upd_en   = 1'b0;
    vsum_ext = {1'b0, rd_q.vsum} + 41'(item_q.data2);
    diff     = item_q.now_ms - rd_q.last_hit;
    case (item_q.opcode)
      OP_MIDI: begin
        if ((item_q.status[7:4] == NOTE_ON_NIBBLE) && (item_q.data2 != 8'd0) && dev_ok_q) begin
          if (!ok_q || !rd_q.mapped) begin
            res.outcome = OUT_UNMAPPED;
          end else begin
            upd_en       = 1'b1;
            res.key_code = rd_q.key;
            if (stats_enable) begin
              new_e.vsum = vsum_ext[40] ? '1 : vsum_ext[39:0];
            end
            if (item_q.data2 < 8'(rd_q.vel_thr)) begin
              res.outcome = OUT_VEL_BLK;
              if (stats_enable && (rd_q.vblk != '1)) begin
                new_e.vblk = rd_q.vblk + 32'd1;
              end
            end else begin
              new_e.last_hit = item_q.now_ms;
              res.elapsed_ms = diff;
              if (diff < 32'(rd_q.overhit)) begin
                res.outcome = OUT_OVR_BLK;
                if (stats_enable && (rd_q.oblk != '1)) begin
                  new_e.oblk = rd_q.oblk + 32'd1;
                end
              end else begin
                res.outcome = OUT_PRESSED;
                if (stats_enable && (rd_q.hits != '1)) begin
                  new_e.hits = rd_q.hits + 32'd1;
                end
              end
            end
          end
        end
      end
      OP_WRITE: begin
        if (ok_q) begin
          upd_en        = 1'b1;
          new_e.mapped  = item_q.entry_mapped;
          new_e.key     = item_q.entry_key;
          new_e.vel_thr = item_q.entry_vel_threshold;
          new_e.overhit = (item_q.entry_overhit_ms > OVERHIT_MAX) ? OVERHIT_MAX
                                                                 : item_q.entry_overhit_ms;
          res.outcome   = OUT_WRITTEN;
        end
      end
      OP_STATS: begin
        res.outcome = OUT_STATS;
        if (ok_q) begin
          res.key_code        = rd_q.mapped ? rd_q.key : 8'd0;
          res.hit_count       = rd_q.hits;
          res.velocity_sum    = rd_q.vsum;
          res.velocity_blocks = rd_q.vblk;
          res.overhit_blocks  = rd_q.oblk;
        end
      end
      default: begin
        res.outcome = OUT_IGNORED;
      end
    endcase
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

endmodule

FILE: rtl/core/midi_note_trigger_filter_core.sv
// MIDI note trigger filter.
// A word is accepted at a rising edge with start high and busy low. Opcode
// selects a MIDI message, a write of one mapping entry, or a read of one
// entry's statistics; every accepted word gives exactly one result word.
// The word is captured with its registered read of the entry table, then
// the execute state does the update, write-back and result load. The
// result is on result with done high for a single cycle, and is taken at
// the edge that ends that cycle. The receiver cannot hold it off; it must
// take it in that cycle. The block takes no new word while one is in
// flight; busy is low again in the cycle done is high, so a new word can
// be accepted while the last result is shown.
// After reset the block clears the entry table, one entry per cycle, for
// all DEVICES * 128 entries (512 at the default of four devices) with busy high.
// stats_enable resets to 0 and may be written through cfg_we and cfg_wdata
// at any time; it should change only while no word is in flight.
module midi_note_trigger_filter_core
  import mntf_pkg::*;
#(
  parameter int DEVICES = DEVICES_DEF
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  item,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output out_word_t result,
  output logic      done
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  mntf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Entry table, decode and result logic.
  mntf_dp #(
    .DEVICES (DEVICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result),
    .done      (done)
  );

  // An accepted word always yields its result.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##2 done)
    else $error("result word missing two cycles after accept");

  // The block is busy in the cycle after it accepts a word.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("second word accepted while one is in flight");

  // A result is shown only once the block is free again.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Results come one at a time; done is never high back to back.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule
